// ===== design/krt_pkg.sv =====
// Shared constants and types of the keyed record table.
`default_nettype none
package krt_pkg;

    localparam int TABLE_CAPACITY = 64;
    localparam int KEY_WORDS      = 4;
    localparam int TAG_W          = 16;
    localparam int WORD_W         = 32;
    localparam int KEY_W          = KEY_WORDS * WORD_W;
    localparam int IDX_W          = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;
    localparam int CNT_W          = $clog2(TABLE_CAPACITY + 1);
    localparam int STATUS_W       = 2;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_ADD    = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [TAG_W-1:0] tag_t;
    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        idx_t tag_rd_addr;
        idx_t key_rd_addr;
        logic tag_we;
        logic key_we;
        idx_t wr_addr;
        tag_t wr_tag;
        key_t wr_key;
    } mem_cmd_t;

endpackage
`default_nettype wire

// ===== design/krt_req_if.sv =====
// Request channel of the keyed record table.
`default_nettype none
interface krt_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] tag;
    logic [31:0] key_word_0;
    logic [31:0] key_word_1;
    logic [31:0] key_word_2;
    logic [31:0] key_word_3;

    modport source (
        output valid, opcode, tag, key_word_0, key_word_1, key_word_2, key_word_3,
        input  ready
    );
    modport sink (
        input  valid, opcode, tag, key_word_0, key_word_1, key_word_2, key_word_3,
        output ready
    );
endinterface
`default_nettype wire

// ===== design/krt_rsp_if.sv =====
// Result channel of the keyed record table.
`default_nettype none
interface krt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] found_word_0;
    logic [31:0] found_word_1;
    logic [31:0] found_word_2;
    logic [31:0] found_word_3;

    modport source (
        output valid, status, found_word_0, found_word_1, found_word_2, found_word_3,
        input  ready
    );
    modport sink (
        input  valid, status, found_word_0, found_word_1, found_word_2, found_word_3,
        output ready
    );
endinterface
`default_nettype wire

// ===== design/krt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module krt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== design/krt_ctrl.sv =====
// Sequencer of the keyed record table: tag scan, update and result register.
`default_nettype none
module krt_ctrl (
    input  wire logic       clk,
    input  wire logic       rst_n,
    krt_req_if.sink         req,
    krt_rsp_if.source       rsp,
    output krt_pkg::mem_cmd_t mem_cmd,
    input  wire krt_pkg::tag_t tag_rdata,
    input  wire krt_pkg::key_t key_rdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_ACT  = 3'd2;
    localparam logic [2:0] S_KEY  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                    state_reg, state_next;
    krt_pkg::cnt_t                 count_reg, count_next;
    krt_pkg::cnt_t                 scan_idx_reg, scan_idx_next;
    logic                          cmp_valid_reg, cmp_valid_next;
    krt_pkg::idx_t                 cmp_idx_reg, cmp_idx_next;
    logic                          hit_reg, hit_next;
    krt_pkg::idx_t                 hit_idx_reg, hit_idx_next;
    logic                          rsp_valid_reg, rsp_valid_next;

    logic                          op_reg, op_next;
    krt_pkg::tag_t                 tag_reg, tag_next;
    krt_pkg::key_t                 key_reg, key_next;
    logic [krt_pkg::STATUS_W-1:0]  status_reg, status_next;
    krt_pkg::key_t                 res_key_reg, res_key_next;
    logic [krt_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;
    krt_pkg::key_t                 out_key_reg, out_key_next;

    logic                          accept;
    logic                          issue;
    krt_pkg::cnt_t                 cmp_cnt;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign issue     = (scan_idx_reg < count_reg);
    assign cmp_cnt   = krt_pkg::CNT_W'(cmp_idx_reg) + krt_pkg::CNT_W'(1);

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.found_word_0 = out_key_reg[31:0];
    assign rsp.found_word_1 = out_key_reg[63:32];
    assign rsp.found_word_2 = out_key_reg[95:64];
    assign rsp.found_word_3 = out_key_reg[127:96];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        rsp_valid_next  = rsp_valid_reg;
        op_next         = op_reg;
        tag_next        = tag_reg;
        key_next        = key_reg;
        status_next     = status_reg;
        res_key_next    = res_key_reg;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;

        mem_cmd.tag_rd_addr = scan_idx_reg[krt_pkg::IDX_W-1:0];
        mem_cmd.key_rd_addr = hit_idx_reg;
        mem_cmd.tag_we      = 1'b0;
        mem_cmd.key_we      = 1'b0;
        mem_cmd.wr_addr     = hit_reg ? hit_idx_reg : count_reg[krt_pkg::IDX_W-1:0];
        mem_cmd.wr_tag      = tag_reg;
        mem_cmd.wr_key      = key_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next        = req.opcode;
                    tag_next       = req.tag;
                    key_next       = {req.key_word_3, req.key_word_2,
                                      req.key_word_1, req.key_word_0};
                    scan_idx_next  = '0;
                    cmp_valid_next = 1'b0;
                    hit_next       = 1'b0;
                    state_next     = (count_reg == '0) ? S_ACT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + krt_pkg::CNT_W'(1);
                end
                cmp_valid_next = issue;
                cmp_idx_next   = scan_idx_reg[krt_pkg::IDX_W-1:0];
                if (cmp_valid_reg && (tag_rdata == tag_reg))
                begin
                    hit_next       = 1'b1;
                    hit_idx_next   = cmp_idx_reg;
                    cmp_valid_next = 1'b0;
                    state_next     = S_ACT;
                end
                else if (cmp_valid_reg && (cmp_cnt == count_reg))
                begin
                    cmp_valid_next = 1'b0;
                    state_next     = S_ACT;
                end
            end
            S_ACT:
            begin
                res_key_next = '0;
                if (op_reg == krt_pkg::OP_LOOKUP)
                begin
                    if (hit_reg)
                    begin
                        state_next = S_KEY;
                    end
                    else
                    begin
                        status_next = krt_pkg::STATUS_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    if (hit_reg)
                    begin
                        mem_cmd.key_we = 1'b1;
                        status_next    = krt_pkg::STATUS_OK;
                    end
                    else if (count_reg < krt_pkg::CNT_W'(krt_pkg::TABLE_CAPACITY))
                    begin
                        mem_cmd.tag_we = 1'b1;
                        mem_cmd.key_we = 1'b1;
                        count_next     = count_reg + krt_pkg::CNT_W'(1);
                        status_next    = krt_pkg::STATUS_OK;
                    end
                    else
                    begin
                        status_next = krt_pkg::STATUS_FULL;
                    end
                    state_next = S_DONE;
                end
            end
            S_KEY:
            begin
                res_key_next = key_rdata;
                status_next  = krt_pkg::STATUS_OK;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    out_status_next = status_reg;
                    out_key_next    = res_key_reg;
                    rsp_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            hit_reg       <= 1'b0;
            hit_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
            hit_reg       <= hit_next;
            hit_idx_reg   <= hit_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        tag_reg        <= tag_next;
        key_reg        <= key_next;
        status_reg     <= status_next;
        res_key_reg    <= res_key_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
    end

endmodule
`default_nettype wire

// ===== design/keyed_record_table.sv =====
// Keyed record table: up to TABLE_CAPACITY records, each a 16-bit tag with a
// 128-bit key, searched linearly in insertion order. A lookup returns the key
// of the first entry whose tag matches, else status not found with zero words.
// An add overwrites the key of a matching entry, else appends a new entry, or
// returns table full. Tags and keys sit in two synchronous RAMs; the tag RAM
// has one read port and one entry is compared per cycle. A request passes
// through acceptance, the tag scan with its read latency, the update or
// decision step, and the hand-off to the result register; a lookup that hits
// adds a key read before the hand-off. An empty table skips the scan. The
// worst case is a lookup that hits the last entry of a full table. One
// request is worked at a time; a finished result waits in its own register
// while the next request is taken, and the hand-off of the next result
// stalls for as long as the receiver holds off. No clearing pass is needed
// after reset.
`default_nettype none
module keyed_record_table (
    input  wire logic clk,
    input  wire logic rst_n,
    krt_req_if.sink   req,
    krt_rsp_if.source rsp
);

    krt_pkg::mem_cmd_t mem_cmd;
    krt_pkg::tag_t     tag_rdata;
    krt_pkg::key_t     key_rdata;

    krt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .mem_cmd   (mem_cmd),
        .tag_rdata (tag_rdata),
        .key_rdata (key_rdata)
    );

    krt_ram #(
        .WIDTH (krt_pkg::TAG_W),
        .DEPTH (krt_pkg::TABLE_CAPACITY)
    ) u_tag_ram (
        .clk   (clk),
        .we    (mem_cmd.tag_we),
        .waddr (mem_cmd.wr_addr),
        .wdata (mem_cmd.wr_tag),
        .raddr (mem_cmd.tag_rd_addr),
        .rdata (tag_rdata)
    );

    krt_ram #(
        .WIDTH (krt_pkg::KEY_W),
        .DEPTH (krt_pkg::TABLE_CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (mem_cmd.key_we),
        .waddr (mem_cmd.wr_addr),
        .wdata (mem_cmd.wr_key),
        .raddr (mem_cmd.key_rd_addr),
        .rdata (key_rdata)
    );

endmodule
`default_nettype wire

// ===== tb/tb_keyed_record_table.sv =====
// Testbench of the keyed record table: directed and random requests against a table predictor.
`timescale 1ns / 100ps
module tb_keyed_record_table;

    localparam int RANDOM_REQUESTS = 1900;
    localparam int TAG_POOL_SIZE   = 96;
    localparam int IDLE_PERCENT    = 21;
    localparam int HOLDOFF_LENGTH  = 400;
    localparam int CYCLE_LIMIT     = 1000000;

    typedef logic [krt_pkg::KEY_WORDS-1:0][krt_pkg::WORD_W-1:0] key_words_t;

    typedef struct packed {
        logic          opcode;
        krt_pkg::tag_t tag;
        key_words_t    key;
    } table_request_t;

    typedef struct packed {
        logic [krt_pkg::STATUS_W-1:0] status;
        key_words_t                   words;
    } table_result_t;

    class record_table_model;
        krt_pkg::tag_t entry_tag [krt_pkg::TABLE_CAPACITY];
        key_words_t    entry_key [krt_pkg::TABLE_CAPACITY];
        int            filled;
        table_result_t awaited_results[$];
        int            mismatches;

        function new();
            filled     = 0;
            mismatches = 0;
        endfunction

        function void note_request(table_request_t r);
            int            hit;
            table_result_t outcome;
            hit           = -1;
            outcome.words = '0;
            for (int i = 0; i < filled; i++)
            begin
                if (hit < 0 && entry_tag[i] == r.tag)
                    hit = i;
            end
            if (r.opcode == krt_pkg::OP_LOOKUP)
            begin
                if (hit >= 0)
                begin
                    outcome.status = krt_pkg::STATUS_OK;
                    outcome.words  = entry_key[hit];
                end
                else
                    outcome.status = krt_pkg::STATUS_NOT_FOUND;
            end
            else if (hit >= 0)
            begin
                entry_key[hit] = r.key;
                outcome.status = krt_pkg::STATUS_OK;
            end
            else if (filled < krt_pkg::TABLE_CAPACITY)
            begin
                entry_tag[filled] = r.tag;
                entry_key[filled] = r.key;
                filled++;
                outcome.status = krt_pkg::STATUS_OK;
            end
            else
                outcome.status = krt_pkg::STATUS_FULL;
            awaited_results.push_back(outcome);
        endfunction

        function void check_result(table_result_t got);
            table_result_t want;
            if (awaited_results.size() == 0)
            begin
                $error("result with no request outstanding: status %0d", got.status);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            for (int j = 0; j < krt_pkg::KEY_WORDS; j++)
            begin
                if (got.words[j] !== want.words[j])
                begin
                    $error("found_word_%0d: expected %h, actual %h",
                           j, want.words[j], got.words[j]);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    int            cycle_count;
    int            holdoff_cycles;
    bit            steady;
    krt_pkg::tag_t tag_pool [TAG_POOL_SIZE];

    record_table_model model = new();

    krt_req_if req();
    krt_rsp_if rsp();

    keyed_record_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        table_request_t seen_req;
        table_result_t  seen_rsp;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                seen_req.opcode = req.opcode;
                seen_req.tag    = req.tag;
                seen_req.key    = {req.key_word_3, req.key_word_2,
                                   req.key_word_1, req.key_word_0};
                model.note_request(seen_req);
            end
            if (rsp.valid && rsp.ready)
            begin
                seen_rsp.status = rsp.status;
                seen_rsp.words  = {rsp.found_word_3, rsp.found_word_2,
                                   rsp.found_word_1, rsp.found_word_0};
                model.check_result(seen_rsp);
            end
        end
    end

    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                rsp.ready <= 1'b0;
            else if (holdoff_cycles > 0)
            begin
                rsp.ready <= 1'b0;
                holdoff_cycles--;
            end
            else if (steady)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    function automatic table_request_t make_request(logic op, krt_pkg::tag_t t,
                                                    key_words_t k);
        table_request_t r;
        r.opcode = op;
        r.tag    = t;
        r.key    = k;
        return r;
    endfunction

    function automatic key_words_t random_key();
        key_words_t k;
        for (int j = 0; j < krt_pkg::KEY_WORDS; j++)
            k[j] = $urandom;
        return k;
    endfunction

    function automatic table_request_t random_request();
        krt_pkg::tag_t t;
        if ($urandom_range(99) < 70)
            t = tag_pool[$urandom_range(TAG_POOL_SIZE - 1)];
        else
            t = krt_pkg::tag_t'($urandom_range(65535));
        return make_request($urandom_range(1) ? krt_pkg::OP_ADD : krt_pkg::OP_LOOKUP,
                            t, random_key());
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(table_request_t r, bit may_idle);
        if (may_idle && !steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.opcode     <= r.opcode;
        req.tag        <= r.tag;
        req.key_word_0 <= r.key[0];
        req.key_word_1 <= r.key[1];
        req.key_word_2 <= r.key[2];
        req.key_word_3 <= r.key[3];
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        while (model.awaited_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cycle_count    = 0;
        holdoff_cycles = 0;
        steady         = 1'b0;
        req.valid      = 1'b0;
        req.opcode     = krt_pkg::OP_LOOKUP;
        req.tag        = '0;
        req.key_word_0 = '0;
        req.key_word_1 = '0;
        req.key_word_2 = '0;
        req.key_word_3 = '0;
        for (int i = 0; i < TAG_POOL_SIZE; i++)
            tag_pool[i] = krt_pkg::tag_t'($urandom_range(65535));
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(make_request(krt_pkg::OP_LOOKUP, 16'h1234, random_key()), 0);
        send_request(make_request(krt_pkg::OP_ADD, 16'h0000, '0), 0);
        send_request(make_request(krt_pkg::OP_ADD, 16'hFFFF, '1), 0);
        send_request(make_request(krt_pkg::OP_LOOKUP, 16'h0000, '1), 0);
        send_request(make_request(krt_pkg::OP_LOOKUP, 16'hFFFF, '0), 0);
        send_request(make_request(krt_pkg::OP_ADD, 16'h0000, {4{32'hA5A5_5A5A}}), 0);
        send_request(make_request(krt_pkg::OP_LOOKUP, 16'h0000, random_key()), 0);
        send_request(make_request(krt_pkg::OP_LOOKUP, 16'h0001, '1), 0);
        send_request(make_request(krt_pkg::OP_LOOKUP, 16'h8000, random_key()), 0);
        send_request(make_request(krt_pkg::OP_ADD, 16'hFFFF, '0), 0);
        send_request(make_request(krt_pkg::OP_LOOKUP, 16'hFFFF, random_key()), 0);
        send_request(make_request(krt_pkg::OP_ADD, 16'h8000, random_key()), 0);
        send_request(make_request(krt_pkg::OP_ADD, 16'h0001, random_key()), 0);
        send_request(make_request(krt_pkg::OP_LOOKUP, 16'h8000, '0), 0);
        send_request(make_request(krt_pkg::OP_LOOKUP, 16'h0001, '0), 0);
        send_request(make_request(krt_pkg::OP_LOOKUP, 16'h0000, '0), 0);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == 300)
                holdoff_cycles = HOLDOFF_LENGTH;
            if (n == 1300)
                drain_results();
            steady = (n >= 800 && n < 1100);
            send_request(random_request(), 1);
        end
        steady = 1'b0;

        drain_results();
        repeat (krt_pkg::TABLE_CAPACITY + 10) @(posedge clk);
        if (model.mismatches == 0 && model.awaited_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
